// ----- rtl/rgbhsv_pkg.sv -----
// Package for the RGB hue, saturation and value adjuster.
// Holds the payload structs, coefficient types, register codes and the sine table.
// No dependencies.
package rgbhsv_pkg;

	localparam int COEF_FRAC_BITS_DEFAULT = 14;
	localparam int SINE_TABLE_ENTRIES = 91;
	localparam int SINE_IDX_W = $clog2(SINE_TABLE_ENTRIES);
	localparam int SINE_W = 15;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 10;
	localparam int COEF_W = 24;
	localparam int COEF_CNT_W = 3;
	localparam logic [COEF_CNT_W-1:0] COEF_LATENCY = 3'd7;
	localparam logic [15:0] INV_SQRT3_Q16 = 16'd37838;
	localparam logic [24:0] RECIP3_Q26 = 25'd22369622;
	localparam logic signed [25:0] UNITY_Q22 = 26'sd4194304;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_HUE        = 2'd0,
		REG_SATURATION = 2'd1,
		REG_GAIN       = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} rgb_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} rgb_out_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] diag;
		logic signed [COEF_W-1:0] plus;
		logic signed [COEF_W-1:0] minus;
	} coef_set_t;

	localparam logic [SINE_W-1:0] SINE_Q14 [SINE_TABLE_ENTRIES] = '{
		15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
		15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
		15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
		15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
		15'd5604,  15'd5871,  15'd6138,  15'd6402,  15'd6664,
		15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
		15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
		15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
		15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
		15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
		15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
		15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
		15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
		15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
		15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
		15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
		15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
		15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
		15'd16384
	};

endpackage

// ----- rtl/rgbhsv_coef_unit.sv -----
// Configuration registers and the coefficient pipeline of the adjuster.
// Every register write to a known index restarts a seven-stage recompute of the matrix coefficients.
// Depends on rgbhsv_pkg.
module rgbhsv_coef_unit import rgbhsv_pkg::*; #(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output coef_set_t              coef,
	output logic                   busy
);

	localparam int SH = 30 - COEF_FRAC_BITS;
	localparam logic [37:0] ROUND_HALF = 38'd1 << (SH - 1);

	logic [8:0] hue_q;
	logic [9:0] sat_q;
	logic [9:0] gain_q;
	logic [COEF_CNT_W-1:0] cnt_q;
	coef_set_t coef_q;
	logic cfg_hit;

	logic signed [15:0] sin_s1, cos_s1;
	logic signed [24:0] c_s2, s_s2;
	logic signed [24:0] c_s3;
	logic [24:0] num_mag_s3;
	logic num_neg_s3;
	logic [23:0] s_mag_s3;
	logic s_neg_s3;
	logic signed [24:0] c_s4;
	logic [23:0] t_mag_s4;
	logic t_neg_s4;
	logic [39:0] k_prod_s4;
	logic k_neg_s4;
	logic signed [26:0] diag_s5, plus_s5, minus_s5;
	logic signed [37:0] diag_s6, plus_s6, minus_s6;

	logic [8:0] hue_mod, hue_cos;
	logic [9:0] hue_cos_sum;
	logic signed [26:0] c_full, s_full;
	logic signed [25:0] num, num_abs;
	logic signed [24:0] s_abs;
	logic [49:0] t_prod;
	logic [39:0] k_prod, k_round;
	logic signed [26:0] t_val, k_val, c_ext;
	logic signed [10:0] gain_s;

	function automatic logic signed [15:0] sine_deg(input logic [8:0] h);
		logic [8:0] idx;
		logic neg;
		logic [SINE_W-1:0] mag;
		if (h <= 9'd90) begin
			idx = h;
			neg = 1'b0;
		end else if (h <= 9'd180) begin
			idx = 9'd180 - h;
			neg = 1'b0;
		end else if (h <= 9'd270) begin
			idx = h - 9'd180;
			neg = 1'b1;
		end else begin
			idx = 9'd360 - h;
			neg = 1'b1;
		end
		mag = SINE_Q14[idx[SINE_IDX_W-1:0]];
		sine_deg = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	function automatic logic signed [COEF_W-1:0] to_coef(input logic signed [37:0] x);
		logic [37:0] mag, rnd;
		logic signed [38:0] v;
		mag = x[37] ? 38'(-x) : 38'(x);
		rnd = (mag + ROUND_HALF) >> SH;
		v = x[37] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
		if (v > 39'sd8388607) begin
			to_coef = 24'sh7FFFFF;
		end else if (v < -39'sd8388608) begin
			to_coef = 24'sh800000;
		end else begin
			to_coef = v[COEF_W-1:0];
		end
	endfunction

	always_comb begin
		unique case (cfg_index)
			REG_HUE, REG_SATURATION, REG_GAIN: cfg_hit = cfg_write;
			default: cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q <= '0;
			sat_q <= 10'd256;
			gain_q <= 10'd256;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_HUE: hue_q <= cfg_data[8:0];
				REG_SATURATION: sat_q <= cfg_data;
				REG_GAIN: gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		hue_mod = (hue_q >= 9'd360) ? hue_q - 9'd360 : hue_q;
		hue_cos_sum = {1'b0, hue_mod} + 10'd90;
		hue_cos = (hue_cos_sum >= 10'd360) ? 9'(hue_cos_sum - 10'd360) : hue_cos_sum[8:0];

		c_full = $signed({1'b0, sat_q}) * cos_s1;
		s_full = $signed({1'b0, sat_q}) * sin_s1;

		num = UNITY_Q22 - 26'(c_s2);
		num_abs = num[25] ? -num : num;
		s_abs = s_s2[24] ? -s_s2 : s_s2;

		t_prod = num_mag_s3 * RECIP3_Q26;
		k_prod = s_mag_s3 * INV_SQRT3_Q16;

		k_round = k_prod_s4 + 40'd32768;
		t_val = t_neg_s4 ? -$signed({3'b0, t_mag_s4}) : $signed({3'b0, t_mag_s4});
		k_val = k_neg_s4 ? -$signed({3'b0, k_round[39:16]}) : $signed({3'b0, k_round[39:16]});
		c_ext = 27'(c_s4);

		gain_s = $signed({1'b0, gain_q});
	end

	always_ff @(posedge clk) begin
		sin_s1 <= sine_deg(hue_mod);
		cos_s1 <= sine_deg(hue_cos);

		c_s2 <= c_full[24:0];
		s_s2 <= s_full[24:0];

		c_s3 <= c_s2;
		num_neg_s3 <= num[25];
		num_mag_s3 <= num_abs[24:0];
		s_neg_s3 <= s_s2[24];
		s_mag_s3 <= s_abs[23:0];

		c_s4 <= c_s3;
		t_neg_s4 <= num_neg_s3;
		t_mag_s4 <= t_prod[49:26];
		k_neg_s4 <= s_neg_s3;
		k_prod_s4 <= k_prod;

		diag_s5 <= c_ext + t_val;
		plus_s5 <= t_val + k_val;
		minus_s5 <= t_val - k_val;

		diag_s6 <= diag_s5 * gain_s;
		plus_s6 <= plus_s5 * gain_s;
		minus_s6 <= minus_s5 * gain_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			coef_q.diag <= COEF_W'(1) << COEF_FRAC_BITS;
			coef_q.plus <= '0;
			coef_q.minus <= '0;
		end else begin
			if (cfg_hit) begin
				cnt_q <= COEF_LATENCY;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (!cfg_hit && cnt_q == COEF_CNT_W'(1)) begin
				coef_q.diag <= to_coef(diag_s6);
				coef_q.plus <= to_coef(plus_s6);
				coef_q.minus <= to_coef(minus_s6);
			end
		end
	end

	assign coef = coef_q;
	assign busy = (cnt_q != '0);

endmodule

// ----- rtl/rgbhsv_color_matrix.sv -----
// Pixel path of the adjuster: input register, 3x3 matrix multiply with clamp, result register.
// Depends on rgbhsv_pkg.
module rgbhsv_color_matrix import rgbhsv_pkg::*; #(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pixel_valid,
	output logic      pixel_stall,
	input  rgb_in_t   pixel,
	output logic      result_valid,
	input  logic      result_stall,
	output rgb_out_t  result,
	input  coef_set_t coef,
	input  logic      hold
);

	logic valid_s1;
	rgb_in_t pixel_s1;
	logic result_valid_q;
	rgb_out_t result_q;
	logic out_ready, s1_ready, s1_load, out_load;
	rgb_out_t mixed;

	function automatic logic [7:0] mix_row(
		input logic [7:0] a,
		input logic [7:0] b,
		input logic [7:0] c,
		input logic signed [COEF_W-1:0] ka,
		input logic signed [COEF_W-1:0] kb,
		input logic signed [COEF_W-1:0] kc
	);
		logic signed [34:0] pa, pb, pc, acc, shifted;
		pa = $signed({1'b0, a}) * ka;
		pb = $signed({1'b0, b}) * kb;
		pc = $signed({1'b0, c}) * kc;
		acc = pa + pb + pc;
		shifted = acc >>> COEF_FRAC_BITS;
		if (acc <= 35'sd0) begin
			mix_row = 8'd0;
		end else if (shifted > 35'sd255) begin
			mix_row = 8'hFF;
		end else begin
			mix_row = shifted[7:0];
		end
	endfunction

	assign out_ready = !result_valid_q || !result_stall;
	assign s1_ready = !valid_s1 || out_ready;
	assign pixel_stall = !s1_ready || hold;
	assign s1_load = pixel_valid && !pixel_stall;
	assign out_load = valid_s1 && out_ready;

	always_comb begin
		mixed.red_out = mix_row(pixel_s1.red_in, pixel_s1.green_in, pixel_s1.blue_in,
			coef.diag, coef.minus, coef.plus);
		mixed.green_out = mix_row(pixel_s1.red_in, pixel_s1.green_in, pixel_s1.blue_in,
			coef.plus, coef.diag, coef.minus);
		mixed.blue_out = mix_row(pixel_s1.red_in, pixel_s1.green_in, pixel_s1.blue_in,
			coef.minus, coef.plus, coef.diag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= s1_load;
			end
			if (out_ready) begin
				result_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			pixel_s1 <= pixel;
		end
		if (out_load) begin
			result_q <= mixed;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

// ----- rtl/rgb_hue_saturation_value_adjust.sv -----
// Top level of the RGB hue, saturation and value adjuster.
// Instantiates rgbhsv_coef_unit and rgbhsv_color_matrix; depends on rgbhsv_pkg.
//
// Usage:
// Pixels enter on the pixel channel (pixel_valid, pixel_stall, pixel) and
// adjusted pixels leave on the result channel (result_valid, result_stall, result).
// A transaction completes at a rising edge where valid is high and stall is low.
// Each pixel passes an input register and then a result register, which offers its result;
// one pixel is taken every cycle while the receiver does not stall and no coefficient
// recompute is running.
// When the receiver stalls, the result register holds its pixel and the input
// register can still take one more; after that pixel_stall rises.
// Registers are written through cfg_write, cfg_index and cfg_data: index 0 is the
// hue in degrees, 1 the saturation and 2 the gain, both Q2.8.
// A write to a known index recomputes the coefficients in a seven-stage pipeline;
// pixel_stall is held high while that recompute runs.
// Reset restores hue 0, saturation 1.0 and gain 1.0, so pixels pass unchanged,
// and empties both registers of the pixel path.
module rgb_hue_saturation_value_adjust import rgbhsv_pkg::*; #(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pixel_valid,
	output logic                   pixel_stall,
	input  rgb_in_t                pixel,
	output logic                   result_valid,
	input  logic                   result_stall,
	output rgb_out_t               result,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	coef_set_t coef;
	logic coef_busy;

	rgbhsv_coef_unit #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_coef (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.coef(coef),
		.busy(coef_busy)
	);

	rgbhsv_color_matrix #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_matrix (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.coef(coef),
		.hold(coef_busy)
	);

	a_busy_blocks_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		coef_busy |-> pixel_stall)
		else $error("Pixel channel open while coefficients are recomputed.");

	a_write_starts_recompute: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write && (cfg_index == REG_HUE || cfg_index == REG_SATURATION ||
		cfg_index == REG_GAIN) |=> coef_busy)
		else $error("Register write did not start a coefficient recompute.");

	a_free_output_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_stall |-> (pixel_stall == coef_busy))
		else $error("Pixel channel stalled while the result side is free.");

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the RGB hue, saturation and value adjuster.
// Predicts every adjusted pixel in fixed point and compares it against the result channel.
// Depends on rgbhsv_pkg and rgb_hue_saturation_value_adjust.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rgbhsv_pkg::*;

	localparam int FRAC = COEF_FRAC_BITS_DEFAULT;
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam longint INV_SQRT3 = 37838;
	localparam longint COEF_HIGH = (longint'(1) <<< (COEF_W - 1)) - 1;
	localparam longint COEF_LOW = -(longint'(1) <<< (COEF_W - 1));
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int RANDOM_PIXELS_PER_PHASE = 450;
	localparam int PIXELS_PER_SETTING = 90;

	logic clk;
	logic arst_n = 1'b0;
	logic pixel_valid = 1'b0;
	logic pixel_stall;
	rgb_in_t pixel = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	rgb_out_t result;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [8:0] hue_reg = 9'd0;
	logic [9:0] sat_reg = 10'd256;
	logic [9:0] gain_reg = 10'd256;
	logic signed [COEF_W-1:0] diag_k = COEF_W'(1) <<< FRAC;
	logic signed [COEF_W-1:0] plus_k = '0;
	logic signed [COEF_W-1:0] minus_k = '0;

	rgb_out_t predicted_pixels[$];
	rgb_out_t want_px;
	int error_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_trigger = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	int sine_lut [0:90] = '{
		0,     286,   572,   857,   1143,  1428,  1713,  1997,  2280,  2563,
		2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
		5604,  5871,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
		8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860,  10087, 10311,
		10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
		12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
		14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
		15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
		16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
		16384
	};

	rgb_hue_saturation_value_adjust dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	function automatic longint sine_deg_q14(int unsigned deg);
		int unsigned d;
		d = deg % 360;
		if (d <= 90) return sine_lut[d];
		if (d <= 180) return sine_lut[180 - d];
		if (d <= 270) return -sine_lut[d - 180];
		return -sine_lut[360 - d];
	endfunction

	function automatic longint round_away(longint x, int n);
		longint half;
		half = longint'(1) <<< (n - 1);
		if (x >= 0) return (x + half) >>> n;
		return -((-x + half) >>> n);
	endfunction

	function automatic logic signed [COEF_W-1:0] coef_from_q22(longint q22, longint gain);
		longint v;
		v = round_away(q22 * gain, 30 - FRAC);
		if (v > COEF_HIGH) v = COEF_HIGH;
		if (v < COEF_LOW) v = COEF_LOW;
		return v[COEF_W-1:0];
	endfunction

	function automatic void update_coefs();
		longint sat, c, s, t, k, g;
		sat = sat_reg;
		c = sat * sine_deg_q14(int'(hue_reg) + 90);
		s = sat * sine_deg_q14(int'(hue_reg));
		t = ((longint'(1) <<< 22) - c) / 3;
		k = round_away(s * INV_SQRT3, 16);
		g = gain_reg;
		diag_k = coef_from_q22(c + t, g);
		plus_k = coef_from_q22(t + k, g);
		minus_k = coef_from_q22(t - k, g);
	endfunction

	function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_HUE: hue_reg = data[8:0];
			REG_SATURATION: sat_reg = data;
			REG_GAIN: gain_reg = data;
			default: return;
		endcase
		update_coefs();
	endfunction

	function automatic logic [7:0] mix_row(longint a, longint b, longint c,
			longint ka, longint kb, longint kc);
		longint acc;
		acc = a * ka + b * kb + c * kc;
		if (acc <= 0) return 8'd0;
		acc = acc >>> FRAC;
		if (acc > 255) return 8'd255;
		return acc[7:0];
	endfunction

	function automatic rgb_out_t adjust_pixel(rgb_in_t px);
		rgb_out_t o;
		longint r, g, b, d, p, m;
		r = px.red_in;
		g = px.green_in;
		b = px.blue_in;
		d = diag_k;
		p = plus_k;
		m = minus_k;
		o.red_out = mix_row(r, g, b, d, m, p);
		o.green_out = mix_row(r, g, b, p, d, m);
		o.blue_out = mix_row(r, g, b, m, p, d);
		return o;
	endfunction

	function automatic logic [7:0] random_level();
		logic [7:0] v;
		v = 8'($urandom);
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return v;
		endcase
	endfunction

	function automatic rgb_in_t random_pixel();
		rgb_in_t px;
		px.red_in = random_level();
		px.green_in = random_level();
		px.blue_in = random_level();
		return px;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_setting_value();
		logic [CFG_DATA_W-1:0] v;
		v = CFG_DATA_W'($urandom);
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return 10'd256;
			default: return v;
		endcase
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	task automatic set_idling(input int sender_pct, input int receiver_pct);
		sender_idle_pct = sender_pct;
		receiver_stall_pct = receiver_pct;
	endtask

	task automatic send_pixel(input rgb_in_t px);
		while ($urandom_range(99) < sender_idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		predicted_pixels.push_back(adjust_pixel(px));
	endtask

	task automatic drain_results();
		pixel_valid <= 1'b0;
		while (predicted_pixels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		drain_results();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		apply_reg(idx, data);
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
	endtask

	task automatic program_setting(input logic [CFG_DATA_W-1:0] hue,
			input logic [CFG_DATA_W-1:0] sat, input logic [CFG_DATA_W-1:0] gain);
		write_reg(REG_HUE, hue);
		write_reg(REG_SATURATION, sat);
		write_reg(REG_GAIN, gain);
	endtask

	task automatic send_probe_pair();
		send_pixel({8'hFF, 8'h80, 8'h00});
		send_pixel({8'h10, 8'hF0, 8'h7F});
	endtask

	task automatic test_passthrough_at_reset();
		set_idling(0, 0);
		send_pixel({8'h00, 8'h00, 8'h00});
		send_pixel({8'hFF, 8'hFF, 8'hFF});
		send_pixel({8'hFF, 8'h00, 8'h00});
		send_pixel({8'h00, 8'hFF, 8'h00});
		send_pixel({8'h00, 8'h00, 8'hFF});
		send_pixel({8'hAA, 8'h55, 8'hAA});
	endtask

	task automatic test_register_extremes();
		program_setting(10'd90, 10'd256, 10'd256);
		send_probe_pair();
		program_setting(10'd180, 10'd256, 10'd256);
		send_probe_pair();
		program_setting(10'd270, 10'h3FF, 10'd256);
		send_probe_pair();
		program_setting(10'd359, 10'd0, 10'd256);
		send_probe_pair();
		// The hue wraps past a full turn and its top data bit is dropped.
		program_setting(10'd360, 10'd256, 10'd0);
		send_probe_pair();
		program_setting(10'h3FF, 10'h3FF, 10'h3FF);
		send_probe_pair();
		write_reg(REG_UNMAPPED, 10'h3FF);
		send_probe_pair();
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_idling(0, 0);
				1: set_idling(87, 0);
				2: set_idling(0, 87);
				default: set_idling(14, 14);
			endcase
			for (int i = 0; i < RANDOM_PIXELS_PER_PHASE; i++) begin
				if (i % PIXELS_PER_SETTING == 0) begin
					program_setting(random_setting_value(), random_setting_value(),
						random_setting_value());
				end
				send_pixel(random_pixel());
			end
		end
	endtask

	task automatic test_backpressure();
		set_idling(0, 0);
		program_setting(random_setting_value(), random_setting_value(), 10'd256);
		hold_trigger <= hold_trigger + 1;
		for (int i = 0; i < 40; i++) send_pixel(random_pixel());
		drain_results();
		set_idling(14, 14);
		for (int i = 0; i < 20; i++) send_pixel(random_pixel());
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen <= hold_trigger;
			hold_left <= LONG_HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (predicted_pixels.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, result);
				error_count++;
			end else begin
				want_px = predicted_pixels.pop_front();
				check_field("red_out", want_px.red_out, result.red_out);
				check_field("green_out", want_px.green_out, result.green_out);
				check_field("blue_out", want_px.blue_out, result.blue_out);
			end
		end
	end

	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough_at_reset();
		test_register_extremes();
		test_random_traffic();
		test_backpressure();
		set_idling(0, 0);
		drain_results();
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
